/* hw/rtl/mbdc_pkg.sv */
// shared types and constants of the multi-button debouncer with combo detect
`default_nettype none

package mbdc_pkg;

    localparam int RAW_BITS = 10;
    localparam int STABLE_W = 8;
    localparam int HOLD_W = 16;
    localparam int THRESH_W = 8;
    localparam int DATA_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [STABLE_W-1:0] STABLE_MAX = '1;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd3;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd300;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO_HOLD_TICKS = 1'd1;

    // per-tick control into the combo stage
    typedef struct packed {
        logic en;
        logic ack;
        logic both_pressed;
    } tick_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/mbdc_lane.sv */
// one debounce lane: stability counter and debounced state of one channel
`default_nettype none

module mbdc_lane (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          pressed,
    input  wire logic [mbdc_pkg::THRESH_W-1:0] threshold,
    output logic                               deb_next
);
    import mbdc_pkg::*;

    logic                prev_reg;
    logic                prev_next;
    logic [STABLE_W-1:0] cnt_reg;
    logic [STABLE_W-1:0] cnt_next;
    logic                deb_reg;

    always_comb
    begin
        prev_next = prev_reg;
        if (pressed == prev_reg)
        begin
            cnt_next = (cnt_reg == STABLE_MAX) ? cnt_reg : cnt_reg + STABLE_W'(1);
        end
        else
        begin
            cnt_next  = '0;
            prev_next = pressed;
        end
        deb_next = (cnt_next >= threshold) ? pressed : deb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b0;
            cnt_reg  <= '0;
            deb_reg  <= 1'b0;
        end
        else if (en)
        begin
            prev_reg <= prev_next;
            cnt_reg  <= cnt_next;
            deb_reg  <= deb_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mbdc_combo.sv */
// merge stage: joint hold timer of the last two channels and sticky combo flag
`default_nettype none

module mbdc_combo (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mbdc_pkg::tick_ctrl_t        ctrl,
    input  wire logic [mbdc_pkg::HOLD_W-1:0] hold_ticks,
    output logic                             sticky_next
);
    import mbdc_pkg::*;

    logic              active_reg;
    logic              active_next;
    logic [HOLD_W-1:0] elapsed_reg;
    logic [HOLD_W-1:0] elapsed_next;
    logic              sticky_reg;
    logic              sticky_acked;

    always_comb
    begin
        sticky_acked = ctrl.ack ? 1'b0 : sticky_reg;
        sticky_next  = sticky_acked;
        active_next  = 1'b0;
        elapsed_next = '0;
        if (ctrl.both_pressed)
        begin
            active_next = 1'b1;
            if (active_reg)
            begin
                elapsed_next = (elapsed_reg == HOLD_MAX) ? elapsed_reg
                                                         : elapsed_reg + HOLD_W'(1);
                if (!sticky_acked && (elapsed_next >= hold_ticks))
                begin
                    sticky_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            elapsed_reg <= '0;
            sticky_reg  <= 1'b0;
        end
        else if (ctrl.en)
        begin
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
            sticky_reg  <= sticky_next;
        end
    end

    a_idle_elapsed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (elapsed_reg == '0))
        else $error("hold time nonzero while no hold is active");

    a_flag_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sticky_reg) |-> active_reg && $past(active_reg))
        else $error("combo flag set without a running hold");

endmodule

`default_nettype wire

/* hw/rtl/multi_button_debouncer_with_combo_core.sv */
// top level of the multi-button debouncer with combo detect
`default_nettype none

// One item is one poll tick carrying the active-low levels of ten buttons and
// a combo acknowledge bit; each tick gives exactly one result with the
// debounced pressed mask and the sticky combo flag. Every channel has its own
// lane, so a tick is taken every clock cycle while s_tready is high, and its
// result is registered for the output. An output register plus one skid
// register let s_tready stay high for one extra item while m_tready is low.
// Channels at or above the ten input bits read as released; the combo watches
// the two highest channels. Configuration: index 0 is the debounce threshold
// (reset 3), index 1 the combo hold length in ticks (reset 300); write only
// while no item is in flight.
module multi_button_debouncer_with_combo_core #(
    parameter int CHANNELS = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mbdc_pkg::DATA_W-1:0]    s_tdata,   // raw_levels[9:0], ack_combo[10]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [mbdc_pkg::DATA_W-1:0]         m_tdata,   // pressed_mask[9:0], combo_flag[10]
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mbdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mbdc_pkg::HOLD_W-1:0]    cfg_data
);
    import mbdc_pkg::*;

    logic [THRESH_W-1:0] thresh_reg;
    logic [HOLD_W-1:0]   hold_ticks_reg;

    logic                accept;
    logic                take;
    logic [RAW_BITS-1:0] raw_levels;
    logic                ack_combo;
    logic [CHANNELS-1:0] deb_next;
    logic [RAW_BITS-1:0] mask;
    logic                sticky_next;
    tick_ctrl_t          ctrl;
    logic [DATA_W-1:0]   result;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DATA_W-1:0]   out_data_reg;
    logic [DATA_W-1:0]   out_data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    logic [DATA_W-1:0]   skid_data_reg;
    logic [DATA_W-1:0]   skid_data_next;

    assign cfg_ready  = 1'b1;
    assign raw_levels = s_tdata[RAW_BITS-1:0];
    assign ack_combo  = s_tdata[RAW_BITS];
    assign s_tready   = !skid_valid_reg;
    assign accept     = s_tvalid && s_tready;
    assign take       = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg     <= THRESH_RESET;
            hold_ticks_reg <= HOLD_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_THRESHOLD: thresh_reg     <= cfg_data[THRESH_W-1:0];
                CFG_COMBO_HOLD_TICKS:   hold_ticks_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        logic pressed;
        if (i < RAW_BITS)
        begin : g_in
            assign pressed = !raw_levels[i];
        end
        else
        begin : g_none
            assign pressed = 1'b0;
        end

        mbdc_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (accept),
            .pressed   (pressed),
            .threshold (thresh_reg),
            .deb_next  (deb_next[i])
        );
    end

    for (genvar i = 0; i < RAW_BITS; i++)
    begin : g_mask
        if (i < CHANNELS)
        begin : g_bit
            assign mask[i] = deb_next[i];
        end
        else
        begin : g_zero
            assign mask[i] = 1'b0;
        end
    end

    always_comb
    begin
        ctrl.en           = accept;
        ctrl.ack          = ack_combo;
        ctrl.both_pressed = deb_next[CHANNELS-2] && deb_next[CHANNELS-1];
    end

    mbdc_combo u_combo (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .hold_ticks  (hold_ticks_reg),
        .sticky_next (sticky_next)
    );

    assign result = {{(DATA_W - RAW_BITS - 1){1'b0}}, sticky_next, mask};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid item held with empty output register");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready && s_tvalid))
        else $error("skid filled without an output stall");

endmodule

`default_nettype wire

/* sim/mbdc_tick_checker.sv */
// checker for the button debouncer: predicts each tick result and compares it on the output
`timescale 1ns / 100ps

module mbdc_tick_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mbdc_pkg::DATA_W-1:0]    s_tdata,   // raw_levels[9:0], ack_combo[10]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mbdc_pkg::DATA_W-1:0]    m_tdata,   // pressed_mask[9:0], combo_flag[10]
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mbdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbdc_pkg::HOLD_W-1:0]    cfg_data,
    output int                             mismatches,
    output int                             pending
);
    import mbdc_pkg::*;

    localparam int CHANNELS = 10;

    typedef struct packed {
        logic                combo_flag;
        logic [RAW_BITS-1:0] pressed_mask;
    } tick_result_t;

    tick_result_t          expected_ticks[$];
    logic [THRESH_W-1:0]   settle_limit;
    logic [HOLD_W-1:0]     combo_limit;
    logic [CHANNELS-1:0]   last_pressed;
    logic [CHANNELS-1:0]   debounced;
    logic [STABLE_W-1:0]   stable_cnt [CHANNELS];
    logic                  joint_held;
    logic [HOLD_W-1:0]     joint_ticks;
    logic                  combo_latched;
    int                    results_seen;

    task automatic report_mismatch(input string what);
        if (mismatches < 100)
        begin
            $display("%0t ns result %0d: %s", $time, results_seen, what);
        end
        mismatches++;
    endtask

    function automatic tick_result_t debounce_tick(input logic [RAW_BITS-1:0] raw,
                                                   input logic ack);
        tick_result_t res;
        logic         pressed;
        int           ch;
        if (ack)
        begin
            combo_latched = 1'b0;
        end
        for (ch = 0; ch < CHANNELS; ch++)
        begin
            pressed = (ch < RAW_BITS) ? ~raw[ch] : 1'b0;
            if (pressed == last_pressed[ch])
            begin
                if (stable_cnt[ch] != STABLE_MAX)
                begin
                    stable_cnt[ch]++;
                end
            end
            else
            begin
                stable_cnt[ch] = '0;
                last_pressed[ch] = pressed;
            end
            if (stable_cnt[ch] >= settle_limit)
            begin
                debounced[ch] = pressed;
            end
        end
        if (debounced[CHANNELS-2] && debounced[CHANNELS-1])
        begin
            if (!joint_held)
            begin
                joint_held = 1'b1;
                joint_ticks = '0;
            end
            else
            begin
                if (joint_ticks != HOLD_MAX)
                begin
                    joint_ticks++;
                end
                if (!combo_latched && joint_ticks >= combo_limit)
                begin
                    combo_latched = 1'b1;
                end
            end
        end
        else
        begin
            joint_held = 1'b0;
            joint_ticks = '0;
        end
        res.pressed_mask = debounced[RAW_BITS-1:0];
        res.combo_flag = combo_latched;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t got;
        tick_result_t want;
        int           ch;
        if (!rst_n)
        begin
            settle_limit = THRESH_RESET;
            combo_limit = HOLD_TICKS_RESET;
            last_pressed = '0;
            debounced = '0;
            for (ch = 0; ch < CHANNELS; ch++)
            begin
                stable_cnt[ch] = '0;
            end
            joint_held = 1'b0;
            joint_ticks = '0;
            combo_latched = 1'b0;
            results_seen = 0;
            expected_ticks.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE_THRESHOLD: settle_limit = cfg_data[THRESH_W-1:0];
                    CFG_COMBO_HOLD_TICKS:   combo_limit = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                expected_ticks.push_back(debounce_tick(s_tdata[RAW_BITS-1:0],
                                                       s_tdata[RAW_BITS]));
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[RAW_BITS:0];
                if (expected_ticks.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result mask %03h flag %0b",
                                              got.pressed_mask, got.combo_flag));
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    if (got.pressed_mask !== want.pressed_mask)
                    begin
                        report_mismatch($sformatf("pressed_mask %03h, expected %03h",
                                                  got.pressed_mask, want.pressed_mask));
                    end
                    if (got.combo_flag !== want.combo_flag)
                    begin
                        report_mismatch($sformatf("combo_flag %0b, expected %0b",
                                                  got.combo_flag, want.combo_flag));
                    end
                end
                results_seen++;
            end
        end
        pending = expected_ticks.size();
    end

endmodule

/* sim/multi_button_debouncer_with_combo_core_test.sv */
// testbench top for the button debouncer: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module multi_button_debouncer_with_combo_core_test;
    import mbdc_pkg::*;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_MOSTLY, STALL_TOGGLE} stall_mode_t;

    localparam int PHASES = 5;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_W-1:0]    m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [HOLD_W-1:0]    cfg_data = '0;
    int                   mismatches;
    int                   pending;

    int                   burst_left = 0;
    logic                 combo_down = 1'b0;
    logic [THRESH_W-1:0]  phase_settle [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd5};
    logic [HOLD_W-1:0]    phase_hold [PHASES] = '{16'd0, 16'd1, 16'd65535, 16'd10, 16'd40};
    int                   phase_ticks [PHASES] = '{250, 400, 150, 350, 350};

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    multi_button_debouncer_with_combo_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mbdc_tick_checker tick_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    task automatic send_tick(input logic [RAW_BITS-1:0] raw, input logic ack);
        int gap;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(DATA_W-RAW_BITS-1){1'b0}}, ack, raw};
        do @(posedge clk); while (!s_tready);
        burst_left--;
    endtask

    task automatic send_run(input logic [RAW_BITS-1:0] raw, input logic ack, input int count);
        repeat (count) send_tick(raw, ack);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [THRESH_W-1:0] settle, input logic [HOLD_W-1:0] hold);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEBOUNCE_THRESHOLD;
        cfg_data <= {(HOLD_W-THRESH_W)'($urandom_range(0, 255)), settle};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_COMBO_HOLD_TICKS;
        cfg_data <= hold;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int                  sent;
        int                  seg_len;
        int                  kind;
        int                  flip;
        logic                noisy;
        logic [RAW_BITS-1:0] base;
        logic [RAW_BITS-1:0] raw;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                combo_down = ~combo_down;
            end
            kind = $urandom_range(0, 9);
            base = RAW_BITS'($urandom_range(0, 1023));
            if (combo_down)
            begin
                base[RAW_BITS-1:RAW_BITS-2] = 2'b00;
            end
            if (kind < 5)
            begin
                seg_len = $urandom_range(1, 8);
            end
            else if (kind < 8)
            begin
                seg_len = $urandom_range(9, 40);
            end
            else
            begin
                seg_len = $urandom_range(41, 300);
            end
            if (seg_len > count - sent)
            begin
                seg_len = count - sent;
            end
            noisy = ($urandom_range(0, 3) == 0);
            repeat (seg_len)
            begin
                raw = base;
                if (kind == 0)
                begin
                    raw = RAW_BITS'($urandom_range(0, 1023));
                end
                else if (noisy && $urandom_range(0, 2) == 0)
                begin
                    flip = $urandom_range(0, combo_down ? RAW_BITS - 3 : RAW_BITS - 1);
                    raw[flip] = ~raw[flip];
                end
                send_tick(raw, $urandom_range(0, 11) == 0);
            end
            sent += seg_len;
        end
    endtask

    // receiver stalls
    initial
    begin
        stall_mode_t mode;
        int          run_len;
        int          since_holdoff;
        since_holdoff = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            run_len = $urandom_range(4, 40);
            repeat (run_len)
            begin
                case (mode)
                    STALL_NONE:   m_tready <= 1'b1;
                    STALL_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    STALL_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    default:      m_tready <= ~m_tready;
                endcase
                @(posedge clk);
            end
            since_holdoff += run_len;
            if (since_holdoff > 700)
            begin
                m_tready <= 1'b0;
                repeat (50) @(posedge clk);
                since_holdoff = 0;
            end
        end
    end

    initial
    begin
        int p;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_run(10'h3FF, 1'b0, 2);
        send_run(10'h000, 1'b0, 4);
        send_run(10'h155, 1'b0, 1);
        send_run(10'h2AA, 1'b0, 1);
        send_run(10'h000, 1'b1, 1);
        send_run(10'h3FF, 1'b0, 4);
        run_random(350);

        for (p = 0; p < PHASES; p++)
        begin
            wait_idle();
            program_regs(phase_settle[p], phase_hold[p]);
            if (p == 0)
            begin
                // zero threshold and zero hold, then ack while the combo is held
                send_run(10'h0FF, 1'b0, 3);
                send_run(10'h0FF, 1'b1, 2);
                send_run(10'h3FF, 1'b0, 2);
            end
            run_random(phase_ticks[p]);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("** multi_button_debouncer_with_combo_core: PASSED **");
        end
        else
        begin
            $display("** multi_button_debouncer_with_combo_core: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("** multi_button_debouncer_with_combo_core: FAILED **");
        $finish;
    end

endmodule

/* multi_button_debouncer_with_combo_core.f */
hw/rtl/mbdc_pkg.sv
hw/rtl/mbdc_lane.sv
hw/rtl/mbdc_combo.sv
hw/rtl/multi_button_debouncer_with_combo_core.sv
sim/mbdc_tick_checker.sv
sim/multi_button_debouncer_with_combo_core_test.sv
